// ===== hw/rtl/sled_pkg.sv =====
// Shared types, phase codes and pattern tables for the status LED sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sled_pkg;

    localparam int PATTERN_BITS = 16;

    typedef logic [PATTERN_BITS-1:0] t_pat;
    typedef logic [1:0]              t_phase;

    localparam t_phase PH_NOTIFY = 2'd0;
    localparam t_phase PH_ALARM  = 2'd1;
    localparam t_phase PH_MODE   = 2'd2;

    localparam logic       OP_UPDATE = 1'b0;
    localparam logic       OP_TICK   = 1'b1;

    localparam logic [4:0] NO_MODE   = 5'd31;
    localparam t_pat       HEARTBEAT = 16'h1fff;

    localparam t_pat FM_ARMED_BLUE [16] = '{
        16'h0001, 16'h0021, 16'h0421, 16'h0001, 16'h0021, 16'h0421, 16'h0421, 16'h1111,
        16'h1111, 16'h0421, 16'h0421, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001};
    localparam t_pat FM_ARMED_RED [16] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'h0400, 16'h1100,
        16'h1100, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400, 16'h0400};
    localparam t_pat FM_DISARMED_BLUE [16] = '{
        16'h0003, 16'h0063, 16'h0c63, 16'h0003, 16'h0063, 16'h0c63, 16'h0c63, 16'h3333,
        16'h3333, 16'h0c63, 16'h0c63, 16'h0003, 16'h0003, 16'h0003, 16'h0003, 16'h0003};
    localparam t_pat FM_DISARMED_RED [16] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0003, 16'h0003, 16'h0003, 16'h0c00, 16'h3300,
        16'h3300, 16'h0c00, 16'h0c00, 16'h0c00, 16'h0c00, 16'h0c00, 16'h0c00, 16'h0c00};
    localparam t_pat NOTICE_BLUE [4] = '{16'h0000, 16'h093f, 16'h003f, 16'h5555};
    localparam t_pat NOTICE_RED  [4] = '{16'h0000, 16'h000f, 16'h186f, 16'haaaa};
    localparam t_pat ALARM_RED   [4] = '{16'h0000, 16'h0040, 16'h0220, 16'h7ffe};

endpackage

`default_nettype wire

// ===== hw/rtl/status_led_blink_sequencer.sv =====
// Status LED blink sequencer top level: phase control, pattern shifters,
// result queue and APB register. Depends on sled_pkg.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------
//  request   | i_in_valid / o_in_stall | opcode, flight_mode, armed, alarm_level,
//            |                         | notice
//  result    | o_out_valid/i_out_stall | blue_led, red_led (one per tick once running)
//  config    | APB psel/penable/pwrite | reg 0 @ 0x0: alarm_led_present
//
// One request per cycle while o_in_stall is low. Each request is decoded and
// folded into the state in the cycle it is accepted; a tick's LED levels go
// into a two-entry output queue and show once earlier results are taken.
// o_in_stall rises only when both entries hold results not yet taken.
// Reset (synchronous, active low) clears all state and the queue, and sets
// alarm_led_present to 1. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module status_led_blink_sequencer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_opcode,
    input  wire  [3:0]  i_flight_mode,
    input  wire         i_armed,
    input  wire  [1:0]  i_alarm_level,
    input  wire  [1:0]  i_notice,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_blue_led,
    output logic        o_red_led,
    // APB config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- config register ----------------
    logic r_alarm_led_present;
    logic cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == 1'b0);
    assign prdata  = {31'd0, cfg_sel & r_alarm_led_present};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_led_present <= 1'b1;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_alarm_led_present <= pwdata[0];
        end
    end

    // ---------------- sequencer state ----------------
    logic              r_running,  n_running;
    logic [3:0]        r_held_mode, n_held_mode;
    logic              r_held_armed, n_held_armed;
    logic [1:0]        r_held_alarm, n_held_alarm;
    logic [1:0]        r_pending,  n_pending;
    logic [1:0]        r_shown,    n_shown;
    sled_pkg::t_phase  r_phase,    n_phase;
    logic [4:0]        r_tick,     n_tick;
    logic [4:0]        r_last_mode, n_last_mode;
    logic              r_force,    n_force;
    sled_pkg::t_pat    r_blue_pat, n_blue_pat;
    sled_pkg::t_pat    r_red_pat,  n_red_pat;

    logic accept;
    logic push;
    logic [1:0] push_data;   // {blue, red}

    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_running   = r_running;
        n_held_mode = r_held_mode;
        n_held_armed = r_held_armed;
        n_held_alarm = r_held_alarm;
        n_pending   = r_pending;
        n_shown     = r_shown;
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_last_mode = r_last_mode;
        n_force     = r_force;
        n_blue_pat  = r_blue_pat;
        n_red_pat   = r_red_pat;
        push        = 1'b0;
        push_data   = 2'b00;

        if (accept) begin
            if (i_opcode == sled_pkg::OP_UPDATE) begin
                n_running    = 1'b1;
                n_held_mode  = i_flight_mode;
                n_held_armed = i_armed;
                n_held_alarm = i_alarm_level;
                if (r_pending == 2'd0) begin
                    n_pending = i_notice;
                end
            end else if (r_running) begin
                n_tick = r_tick + 5'd1;

                // notification pre-empts; otherwise a mode change restarts mode phase
                if (r_phase != sled_pkg::PH_NOTIFY && r_pending != 2'd0) begin
                    n_shown   = r_pending;
                    n_pending = 2'd0;
                    n_phase   = sled_pkg::PH_NOTIFY;
                    n_tick    = 5'd0;
                end else if (r_last_mode != {1'b0, r_held_mode}) begin
                    n_phase     = sled_pkg::PH_MODE;
                    n_last_mode = {1'b0, r_held_mode};
                    n_tick      = 5'd0;
                    n_force     = 1'b1;
                end

                // end of a 16-tick phase
                if (n_tick[4]) begin
                    n_tick  = 5'd0;
                    n_force = 1'b0;
                    if (n_phase == sled_pkg::PH_NOTIFY) begin
                        n_shown = 2'd0;
                    end
                    n_phase = (n_phase >= sled_pkg::PH_MODE) ? sled_pkg::PH_NOTIFY
                                                             : n_phase + 2'd1;
                end

                if (n_phase == sled_pkg::PH_NOTIFY && n_tick == 5'd0) begin
                    if (n_shown == 2'd0) begin
                        n_phase = sled_pkg::PH_ALARM;
                    end else begin
                        n_blue_pat = sled_pkg::NOTICE_BLUE[n_shown];
                        n_red_pat  = sled_pkg::NOTICE_RED[n_shown];
                    end
                end

                // without the alarm LED the phase is left at once, no reload
                if (n_phase == sled_pkg::PH_ALARM) begin
                    if (!r_alarm_led_present) begin
                        n_phase = sled_pkg::PH_MODE;
                    end else if (n_tick == 5'd0) begin
                        if (r_held_alarm == 2'd0) begin
                            n_phase = sled_pkg::PH_MODE;
                        end else begin
                            n_blue_pat = '0;
                            n_red_pat  = sled_pkg::ALARM_RED[r_held_alarm];
                        end
                    end
                end

                if (n_phase == sled_pkg::PH_MODE && n_tick == 5'd0) begin
                    if (r_held_armed) begin
                        n_blue_pat = sled_pkg::FM_ARMED_BLUE[r_held_mode];
                        n_red_pat  = sled_pkg::FM_ARMED_RED[r_held_mode];
                    end else if (n_force) begin
                        n_blue_pat = sled_pkg::FM_DISARMED_BLUE[r_held_mode];
                        n_red_pat  = sled_pkg::FM_DISARMED_RED[r_held_mode];
                    end else begin
                        n_blue_pat = sled_pkg::HEARTBEAT;
                        n_red_pat  = '0;
                    end
                end

                push       = 1'b1;
                push_data  = {n_blue_pat[0], n_red_pat[0]};
                n_blue_pat = n_blue_pat >> 1;
                n_red_pat  = n_red_pat >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_held_mode  <= 4'd0;
            r_held_armed <= 1'b0;
            r_held_alarm <= 2'd0;
            r_pending    <= 2'd0;
            r_shown      <= 2'd0;
            r_phase      <= sled_pkg::PH_NOTIFY;
            r_tick       <= 5'd0;
            r_last_mode  <= sled_pkg::NO_MODE;
            r_force      <= 1'b0;
            r_blue_pat   <= '0;
            r_red_pat    <= '0;
        end else begin
            r_running    <= n_running;
            r_held_mode  <= n_held_mode;
            r_held_armed <= n_held_armed;
            r_held_alarm <= n_held_alarm;
            r_pending    <= n_pending;
            r_shown      <= n_shown;
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_last_mode  <= n_last_mode;
            r_force      <= n_force;
            r_blue_pat   <= n_blue_pat;
            r_red_pat    <= n_red_pat;
        end
    end

    // ---------------- two-entry result queue ----------------
    logic [1:0] r_q0, n_q0;
    logic [1:0] r_q1, n_q1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_in_stall  = (r_cnt == 2'd2);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_blue_led  = r_q0[1];
    assign o_red_led   = r_q0[0];

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        unique case ({push, pop})
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_q0 = push_data;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = push_data;
                end
            end
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_q0 = push_data;
                end else begin
                    n_q1 = push_data;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_q0  = r_q1;
                n_cnt = r_cnt - 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

`default_nettype wire
